// ----- rtl/core/stsk_pkg.sv -----
// shared constants and types for the stirling number block
`default_nettype none

package stsk_pkg;

  localparam int MAX_N      = 64;
  localparam int VALUE_BITS = 64;
  localparam int FIELD_W    = 7;
  localparam int OUT_W      = 64;
  localparam int CELL_W     = $clog2(MAX_N + 1);
  localparam int IDX_W      = (CELL_W > FIELD_W) ? CELL_W : FIELD_W;
  localparam int SEL_W      = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int PROD_W     = VALUE_BITS + IDX_W;

  // broadcast control for the cell row
  typedef struct packed {
    logic             clear;
    logic             run;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] last_col;
  } stsk_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/stsk_cell.sv -----
// one column cell of the stirling table: holds S(i,j) for its column j
`default_nettype none

module stsk_cell
  import stsk_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire stsk_ctrl_t            ctrl_i,
  input  wire logic [IDX_W-1:0]      col_i,
  input  wire logic [VALUE_BITS-1:0] left_i,
  output logic [VALUE_BITS-1:0]      val_o,
  output logic                       ovf_o
);

  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [PROD_W-1:0]     prod;
  logic [VALUE_BITS:0]   sum;
  logic                  active, is_one, mul_ovf;

  assign active  = ctrl_i.run && (col_i <= ctrl_i.row) && (col_i <= ctrl_i.last_col);
  assign is_one  = (col_i == IDX_W'(1)) || (col_i == ctrl_i.row);
  assign prod    = PROD_W'(val_q) * PROD_W'(col_i);
  assign mul_ovf = |prod[PROD_W-1:VALUE_BITS];
  assign sum     = {1'b0, prod[VALUE_BITS-1:0]} + {1'b0, left_i};

  always_comb begin
    val_d = val_q;
    if (ctrl_i.clear) begin
      val_d = '0;
    end else if (active && is_one) begin
      val_d = VALUE_BITS'(1);
    end else if (active) begin
      val_d = sum[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign ovf_o = active && !is_one && (mul_ovf || sum[VALUE_BITS]);

endmodule

`default_nettype wire

// ----- rtl/core/stirling_second_kind.sv -----
// top level: stirling numbers of the second kind S(n,k) on a chain of column cells
`default_nettype none

// Computes S(n,k), the number of ways to split n distinct objects into k
// non-empty unlabeled subsets, one result item per input item. A row of
// MAX_N column cells holds one row of the table; in each run cycle every cell
// j up to both the row i and k takes its own value and that of its left
// neighbor and forms j*S(i-1,j) + S(i-1,j-1) (or 1 for j equal to 1 or i), so
// the chain advances one table row per cycle. For a general item
// (2 <= k < n <= MAX_N) the accepting edge clears the cells, the run state
// computes rows 1 to n, and the selection state loads column k into the
// output register. The next item can be taken once selection is done. Edge
// cases (n or k zero, k > n, k equal to 1 or n, or n above MAX_N) skip the
// rows: they go from acceptance straight to selection, which loads the output
// register, and the next item can follow once it has. A new item
// is taken as soon as the previous one has left selection, even while its
// result still waits in the output register; a finished item whose result
// finds that register still occupied waits in selection, and the input
// stays stalled meanwhile. Values wrap modulo 2^VALUE_BITS and overflowed is
// set if any product or sum of the item left that range; n above MAX_N
// gives 0 with overflowed set.

module stirling_second_kind
  import stsk_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [FIELD_W-1:0] n_items_i,
  input  wire logic [FIELD_W-1:0] subset_count_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [OUT_W-1:0]        partition_count_o,
  output logic                    overflowed_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  state_e               state_q;
  logic [IDX_W-1:0]     n_q, k_q, row_q;
  logic                 special_q, spec_val_q, flag_q;
  logic                 out_valid_q, out_flag_q;
  logic [OUT_W-1:0]     out_val_q;

  // input decode
  logic                 accept;
  logic [IDX_W-1:0]     n_ext, k_ext;
  logic                 too_big, empty_split, trivial, spec;

  // cell row
  stsk_ctrl_t           ctrl;
  logic [VALUE_BITS-1:0] cell_val [MAX_N];
  logic [MAX_N-1:0]     cell_ovf;
  logic                 any_ovf;
  logic [IDX_W-1:0]     k_m1;
  logic [SEL_W-1:0]     sel;
  logic                 out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign n_ext       = IDX_W'(n_items_i);
  assign k_ext       = IDX_W'(subset_count_i);
  assign too_big     = n_ext > IDX_W'(MAX_N);
  assign empty_split = (n_ext == '0) || (k_ext == '0) || (k_ext > n_ext);
  assign trivial     = (k_ext == IDX_W'(1)) || (k_ext == n_ext);
  assign spec        = too_big || empty_split || trivial;

  // clear on acceptance, run one row per cycle afterwards
  assign ctrl.clear    = accept;
  assign ctrl.run      = (state_q == ST_RUN);
  assign ctrl.row      = row_q;
  assign ctrl.last_col = k_q;

  for (genvar g = 0; g < MAX_N; g++) begin : g_cell
    logic [VALUE_BITS-1:0] left;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_rest
      assign left = cell_val[g-1];
    end
    stsk_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .col_i  (IDX_W'(g + 1)),
      .left_i (left),
      .val_o  (cell_val[g]),
      .ovf_o  (cell_ovf[g])
    );
  end

  assign any_ovf  = |cell_ovf;
  assign k_m1     = k_q - IDX_W'(1);
  assign sel      = k_m1[SEL_W-1:0];
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      k_q         <= '0;
      row_q       <= '0;
      special_q   <= 1'b0;
      spec_val_q  <= 1'b0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_flag_q  <= 1'b0;
      out_val_q   <= '0;
    end else begin
      // output register drains when taken
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            n_q        <= n_ext;
            k_q        <= k_ext;
            row_q      <= IDX_W'(1);
            special_q  <= spec;
            spec_val_q <= !too_big && !empty_split && trivial;
            flag_q     <= too_big;
            state_q    <= spec ? ST_FINISH : ST_RUN;
          end
        end
        ST_RUN: begin
          // sticky overflow across all rows of the item
          flag_q <= flag_q || any_ovf;
          row_q  <= row_q + IDX_W'(1);
          if (row_q == n_q) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_flag_q  <= flag_q;
            out_val_q   <= special_q ? OUT_W'(spec_val_q) : OUT_W'(cell_val[sel]);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign partition_count_o = out_val_q;
  assign overflowed_o      = out_flag_q;

  // row counter stays within the item's rows
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (row_q != '0) && (row_q <= n_q))
    else $error("row counter out of range");

  // last row hands over to result selection
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) && (row_q == n_q) |=> (state_q == ST_FINISH))
    else $error("run did not end after last row");

  // general items only reach selection with 2 <= k < n
  a_general_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) && !special_q |-> (k_q >= IDX_W'(2)) && (k_q < n_q))
    else $error("table selection with edge-case k");

  // too many objects always flags overflow
  a_too_big: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && too_big |=> special_q && flag_q && (state_q == ST_FINISH))
    else $error("oversized n not flagged");

endmodule

`default_nettype wire
